@@ sv/lj_pkg.sv @@
// shared types, constants and saturation helpers for the lennard-jones pair force block
`timescale 1ns / 1ps
package lj_pkg;

	localparam int MAX_ATOMS = 64;
	localparam int ATOM_W    = $clog2(MAX_ATOMS);
	localparam int IDX_W     = 6;
	localparam int CNT_W     = 7;
	localparam int ACC_W     = 48;
	localparam int OUT_W     = 48;
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = 1;
	localparam int QCNT_W    = 2;

	localparam logic [63:0] Q_ONE    = 64'd1 << 24;
	localparam logic [63:0] MAG_CAP  = (64'd1 << 62) - 64'd1;
	localparam logic [63:0] CAP_DIV6 = MAG_CAP / 64'd6;

	localparam logic signed [65:0] ACC_MAX = (66'sd1 <<< (ACC_W - 1)) - 66'sd1;
	localparam logic signed [65:0] ACC_MIN = -ACC_MAX - 66'sd1;
	localparam logic signed [65:0] OUT_MAX = (66'sd1 <<< (OUT_W - 1)) - 66'sd1;
	localparam logic signed [65:0] OUT_MIN = -OUT_MAX - 66'sd1;

	localparam logic [1:0] REG_WELL_DEPTH = 2'd0;
	localparam logic [1:0] REG_SIGMA      = 2'd1;
	localparam logic [1:0] REG_SHIFT      = 2'd2;

	typedef struct packed {
		logic [31:0]        well_depth;
		logic [31:0]        sigma;
		logic signed [31:0] shift;
	} lj_cfg_t;

	typedef struct packed {
		logic               do_pair;
		logic               frame_end;
		logic [IDX_W-1:0]   i;
		logic [IDX_W-1:0]   j;
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] dz;
		logic [31:0]        r;
		logic [CNT_W-1:0]   n;
	} lj_item_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DIVQ, S_MQQ, S_MQ3, S_MA, S_MB, S_ME, S_EACC, S_MT, S_T6, S_DIVK,
		S_MFX, S_MFY, S_MFZ, S_RDJ, S_WRJ, S_RDI, S_WRI,
		S_ROST, S_RORD, S_ROLD, S_ROW, S_CLR
	} lj_state_t;

	function automatic logic signed [65:0] acc_ext(input logic [ACC_W-1:0] v);
		acc_ext = {{(66 - ACC_W){v[ACC_W-1]}}, v};
	endfunction

	function automatic logic [ACC_W-1:0] sat_acc(input logic signed [65:0] v);
		logic signed [65:0] s;
		s = v;
		if (v > ACC_MAX) s = ACC_MAX;
		if (v < ACC_MIN) s = ACC_MIN;
		sat_acc = s[ACC_W-1:0];
	endfunction

	function automatic logic [OUT_W-1:0] sat_out(input logic [ACC_W-1:0] v);
		logic signed [65:0] w;
		logic signed [65:0] s;
		w = acc_ext(v);
		s = w;
		if (w > OUT_MAX) s = OUT_MAX;
		if (w < OUT_MIN) s = OUT_MIN;
		sat_out = s[OUT_W-1:0];
	endfunction

endpackage

@@ sv/lj_front.sv @@
// input side: accepts items, sorts out skipped pairs and queues work for the back end
`timescale 1ns / 1ps
module lj_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                has_pair,
	input  logic [5:0]          first_atom,
	input  logic [5:0]          second_atom,
	input  logic signed [31:0]  delta_x,
	input  logic signed [31:0]  delta_y,
	input  logic signed [31:0]  delta_z,
	input  logic [31:0]         separation,
	input  logic [6:0]          atom_count,
	input  logic                frame_end,
	output lj_pkg::lj_item_t    head,
	output logic                head_valid,
	input  logic                head_pop
);
	import lj_pkg::*;

	lj_item_t          ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	lj_item_t          item;
	logic              push;

	always_comb begin
		item.i         = first_atom;
		item.j         = second_atom;
		item.dx        = delta_x;
		item.dy        = delta_y;
		item.dz        = delta_z;
		item.r         = separation;
		item.frame_end = frame_end;
		item.n         = (atom_count > CNT_W'(MAX_ATOMS)) ? CNT_W'(MAX_ATOMS) : atom_count;
		item.do_pair   = has_pair && (first_atom != second_atom) && (separation != 32'd0)
			&& ({1'b0, first_atom} < CNT_W'(MAX_ATOMS))
			&& ({1'b0, second_atom} < CNT_W'(MAX_ATOMS));
	end

	assign in_ready   = (count_q != QCNT_W'(QDEPTH));
	// items with no pair and no frame end cause nothing and are dropped here
	assign push       = in_valid && in_ready && (item.do_pair || item.frame_end);
	assign head       = ent_q[rd_ptr_q];
	assign head_valid = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (head_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, head_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ sv/lj_mul.sv @@
// shared q.24 multiplier: 64x64 product from four 32x32 partial products, saturated
`timescale 1ns / 1ps
module lj_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] prod
);
	import lj_pkg::*;

	logic [63:0]  a_q, b_q;
	logic [2:0]   step_q;
	logic         busy_q;
	logic [63:0]  pp_q;
	logic [1:0]   pp_sh_q;
	logic [127:0] acc_q;
	logic [31:0]  pa, pb;
	logic [127:0] pp_shifted;

	assign pa = step_q[1] ? a_q[63:32] : a_q[31:0];
	assign pb = step_q[0] ? b_q[63:32] : b_q[31:0];

	always_comb begin
		case (pp_sh_q)
			2'd0:    pp_shifted = {64'd0, pp_q};
			2'd1:    pp_shifted = {32'd0, pp_q, 32'd0};
			2'd2:    pp_shifted = {pp_q, 64'd0};
			default: pp_shifted = '0;
		endcase
	end

	assign done = busy_q && (step_q == 3'd5);
	// (x*y)>>24 with saturation at 2^62-1
	assign prod = (|acc_q[127:86]) ? MAG_CAP : {2'b00, acc_q[85:24]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 3'd1;
			if (step_q == 3'd5) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (step_q < 3'd4) begin
				pp_q    <= pa * pb;
				pp_sh_q <= {1'b0, step_q[1]} + {1'b0, step_q[0]};
			end
			if (step_q >= 3'd1 && step_q <= 3'd4) acc_q <= acc_q + pp_shifted;
		end
	end

endmodule

@@ sv/lj_div.sv @@
// shared restoring divider: 128/64 bit quotient, one bit per cycle, saturated
`timescale 1ns / 1ps
module lj_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num_hi,
	input  logic [63:0] num_lo,
	input  logic [63:0] den,
	output logic        done,
	output logic [63:0] quo
);
	import lj_pkg::*;

	logic [63:0] rem_q, lo_q, den_q, quo_q;
	logic        ovf_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [63:0] rem_sh;
	logic        take;

	assign rem_sh = {rem_q[62:0], lo_q[63]};
	assign take   = rem_q[63] || (rem_sh >= den_q);
	assign done   = busy_q && (cnt_q == 7'd64);
	assign quo    = (ovf_q || quo_q[63] || quo_q[62]) ? MAG_CAP : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 7'd1;
			if (cnt_q == 7'd64) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num_hi;
			lo_q  <= num_lo;
			den_q <= den;
			quo_q <= '0;
			ovf_q <= (num_hi >= den);
		end else if (busy_q && cnt_q != 7'd64) begin
			rem_q <= take ? rem_sh - den_q : rem_sh;
			lo_q  <= {lo_q[62:0], 1'b0};
			quo_q <= {quo_q[62:0], take};
		end
	end

endmodule

@@ sv/lj_back.sv @@
// back end: pair arithmetic sequencer, per-atom force store and frame readout
`timescale 1ns / 1ps
module lj_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lj_pkg::lj_cfg_t          cfg,
	input  lj_pkg::lj_item_t         head,
	input  logic                     head_valid,
	output logic                     head_pop,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [5:0]               atom_index,
	output logic signed [47:0]       force_x,
	output logic signed [47:0]       force_y,
	output logic signed [47:0]       force_z,
	output logic signed [47:0]       total_energy,
	output logic                     last_result
);
	import lj_pkg::*;

	lj_state_t state_q, state_d;
	lj_item_t  it_q;

	logic [63:0] rr_q, q_q, tmp_q, a_q, b_q, k_q;
	logic        tneg_q;
	logic signed [63:0] f_q [3];
	logic [ACC_W-1:0]   energy_q;
	logic        issued_q;
	logic [CNT_W-1:0] ro_idx_q;
	logic        last_q;

	logic [3*ACC_W-1:0] mem_q [MAX_ATOMS];
	logic [3*ACC_W-1:0] rd_q;
	logic [MAX_ATOMS-1:0] vld_q;

	logic        mul_start, mul_done, div_start, div_done;
	logic [63:0] mul_a, mul_b, mul_p, div_hi, div_lo, div_den, div_q;
	logic        is_mul, is_div;
	logic        rd_en, we;
	logic [ATOM_W-1:0] rd_addr, wr_addr;
	logic [3*ACC_W-1:0] wdata;

	logic [63:0] two_a, dif, t6;
	logic        tneg;
	logic        dneg;
	logic [32:0] dabs;
	logic signed [31:0] dsel;
	logic [1:0]  comp;
	logic signed [65:0] e_val;
	logic few_atoms;

	assign is_mul = state_q inside {S_MQQ, S_MQ3, S_MA, S_MB, S_ME, S_MT, S_MFX, S_MFY, S_MFZ};
	assign is_div = state_q inside {S_DIVQ, S_DIVK};

	assign two_a = {a_q[62:0], 1'b0};
	assign tneg  = two_a < Q_ONE;
	assign dif   = tneg ? Q_ONE - two_a : two_a - Q_ONE;
	assign t6    = (tmp_q > CAP_DIV6) ? MAG_CAP : (tmp_q << 2) + (tmp_q << 1);

	always_comb begin
		case (state_q)
			S_MFY:   comp = 2'd1;
			S_MFZ:   comp = 2'd2;
			default: comp = 2'd0;
		endcase
		case (comp)
			2'd1:    dsel = it_q.dy;
			2'd2:    dsel = it_q.dz;
			default: dsel = it_q.dx;
		endcase
	end
	assign dneg = dsel[31];
	assign dabs = dneg ? 33'(-{dsel[31], dsel}) : {1'b0, dsel};

	assign e_val = ((a_q >= Q_ONE) ? $signed({2'b00, tmp_q}) : -$signed({2'b00, tmp_q}))
		- 66'(cfg.shift);

	// operand selection and unit control
	always_comb begin
		mul_start = is_mul && !issued_q;
		div_start = is_div && !issued_q;
		mul_a     = q_q;
		mul_b     = q_q;
		div_hi    = '0;
		div_lo    = {8'd0, cfg.sigma, 24'd0};
		div_den   = {32'd0, it_q.r};
		rd_en     = 1'b0;
		rd_addr   = it_q.j[ATOM_W-1:0];
		head_pop  = 1'b0;
		case (state_q)
			S_IDLE:  head_pop = head_valid;
			S_MQQ:   begin mul_a = q_q; mul_b = q_q; end
			S_MQ3:   begin mul_a = tmp_q; mul_b = q_q; end
			S_MA:    begin mul_a = tmp_q; mul_b = tmp_q; end
			S_MB:    begin mul_a = {30'd0, cfg.well_depth, 2'b00}; mul_b = a_q; end
			S_ME:    begin
				mul_a = b_q;
				mul_b = (a_q >= Q_ONE) ? a_q - Q_ONE : Q_ONE - a_q;
			end
			S_MT:    begin mul_a = b_q; mul_b = dif; end
			S_DIVK:  begin
				div_hi  = {16'd0, tmp_q[63:16]};
				div_lo  = {tmp_q[15:0], 48'd0};
				div_den = rr_q;
			end
			S_MFX, S_MFY, S_MFZ: begin mul_a = k_q; mul_b = {31'd0, dabs}; end
			S_RDJ:   rd_en = 1'b1;
			S_RDI:   begin rd_en = 1'b1; rd_addr = it_q.i[ATOM_W-1:0]; end
			S_RORD:  begin rd_en = 1'b1; rd_addr = ro_idx_q[ATOM_W-1:0]; end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (head_valid) state_d = head.do_pair ? S_DIVQ : S_ROST;
			S_DIVQ:  if (div_done) state_d = S_MQQ;
			S_MQQ:   if (mul_done) state_d = S_MQ3;
			S_MQ3:   if (mul_done) state_d = S_MA;
			S_MA:    if (mul_done) state_d = S_MB;
			S_MB:    if (mul_done) state_d = S_ME;
			S_ME:    if (mul_done) state_d = S_EACC;
			S_EACC:  state_d = S_MT;
			S_MT:    if (mul_done) state_d = S_T6;
			S_T6:    state_d = S_DIVK;
			S_DIVK:  if (div_done) state_d = S_MFX;
			S_MFX:   if (mul_done) state_d = S_MFY;
			S_MFY:   if (mul_done) state_d = S_MFZ;
			S_MFZ:   if (mul_done) state_d = S_RDJ;
			S_RDJ:   state_d = S_WRJ;
			S_WRJ:   state_d = S_RDI;
			S_RDI:   state_d = S_WRI;
			S_WRI:   state_d = it_q.frame_end ? S_ROST : S_IDLE;
			S_ROST:  state_d = (it_q.n == '0) ? S_CLR : S_RORD;
			S_RORD:  state_d = S_ROLD;
			S_ROLD:  state_d = S_ROW;
			S_ROW:   if (out_ready) state_d = last_q ? S_CLR : S_RORD;
			S_CLR:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// accumulator update: add the force to j, subtract it from i
	always_comb begin
		logic [ACC_W-1:0] old_c;
		logic signed [65:0] fd;
		we      = (state_q == S_WRJ) || (state_q == S_WRI);
		wr_addr = (state_q == S_WRI) ? it_q.i[ATOM_W-1:0] : it_q.j[ATOM_W-1:0];
		wdata   = '0;
		for (int c = 0; c < 3; c++) begin
			old_c = vld_q[wr_addr] ? rd_q[c*ACC_W +: ACC_W] : '0;
			fd    = 66'(f_q[c]);
			if (state_q == S_WRI) fd = -fd;
			wdata[c*ACC_W +: ACC_W] = sat_acc(acc_ext(old_c) + fd);
		end
	end

	lj_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(mul_p)
	);

	lj_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num_hi(div_hi), .num_lo(div_lo),
		.den(div_den), .done(div_done), .quo(div_q)
	);

	always_ff @(posedge clk) begin
		if (we) mem_q[wr_addr] <= wdata;
		if (rd_en) rd_q <= mem_q[rd_addr];
	end

	assign few_atoms = it_q.n < CNT_W'(2);

	always_ff @(posedge clk) begin
		if (head_pop) begin
			it_q <= head;
			rr_q <= head.r * head.r;
		end
		if (div_done && state_q == S_DIVQ) q_q <= div_q;
		if (div_done && state_q == S_DIVK) k_q <= div_q;
		if (mul_done) begin
			case (state_q)
				S_MQQ, S_MQ3, S_ME: tmp_q <= mul_p;
				S_MA:    a_q <= mul_p;
				S_MB:    b_q <= mul_p;
				S_MT:    begin tmp_q <= mul_p; tneg_q <= tneg; end
				S_MFX, S_MFY, S_MFZ:
					f_q[comp] <= (tneg_q != dneg) ? -$signed(mul_p) : $signed(mul_p);
				default: ;
			endcase
		end
		if (state_q == S_T6) tmp_q <= t6;
		if (state_q == S_ROLD) begin
			atom_index   <= IDX_W'(ro_idx_q);
			last_q       <= (ro_idx_q + CNT_W'(1)) == it_q.n;
			force_x      <= (few_atoms || !vld_q[ro_idx_q[ATOM_W-1:0]]) ? '0
				: sat_out(rd_q[0 +: ACC_W]);
			force_y      <= (few_atoms || !vld_q[ro_idx_q[ATOM_W-1:0]]) ? '0
				: sat_out(rd_q[ACC_W +: ACC_W]);
			force_z      <= (few_atoms || !vld_q[ro_idx_q[ATOM_W-1:0]]) ? '0
				: sat_out(rd_q[2*ACC_W +: ACC_W]);
			total_energy <= few_atoms ? '0 : sat_out(energy_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			issued_q <= 1'b0;
			energy_q <= '0;
			vld_q    <= '0;
			ro_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (mul_start || div_start) issued_q <= 1'b1;
			else if (mul_done || div_done) issued_q <= 1'b0;
			if (state_q == S_EACC) energy_q <= sat_acc(acc_ext(energy_q) + e_val);
			if (we) vld_q[wr_addr] <= 1'b1;
			if (state_q == S_ROST) ro_idx_q <= '0;
			if (state_q == S_ROW && out_ready) ro_idx_q <= ro_idx_q + CNT_W'(1);
			if (state_q == S_CLR) begin
				vld_q    <= '0;
				energy_q <= '0;
			end
		end
	end

	assign out_valid   = (state_q == S_ROW);
	assign last_result = last_q;

	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_MQQ || state_q == S_MQ3 || state_q == S_MA ||
			state_q == S_MB || state_q == S_ME || state_q == S_MT ||
			state_q == S_MFX || state_q == S_MFY || state_q == S_MFZ))
		else $error("multiplier result outside a multiply step");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIVQ || state_q == S_DIVK))
		else $error("divider result outside a divide step");

	a_out_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (ro_idx_q < it_q.n))
		else $error("readout index past atom count");

	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRI) |-> ($past(state_q) == S_RDI))
		else $error("accumulator write without its read");

endmodule

@@ sv/lennard_jones_pair_force.sv @@
// top level: configuration registers, front queue and back-end sequencer
// a pair holds the back end for two restoring divides in the shared divider, nine products
// through the shared multiplier and the sequencing steps; a frame end adds a start step,
// then read, load and output steps per reported atom plus output stalls, then a clear step
// items with no pair and no frame end are taken and dropped
// reset clears the force store through per-atom valid bits at once: no clearing pass
`timescale 1ns / 1ps
module lennard_jones_pair_force (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               has_pair,
	input  logic [5:0]         first_atom,
	input  logic [5:0]         second_atom,
	input  logic signed [31:0] delta_x,
	input  logic signed [31:0] delta_y,
	input  logic signed [31:0] delta_z,
	input  logic [31:0]        separation,
	input  logic [6:0]         atom_count,
	input  logic               frame_end,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [5:0]         atom_index,
	output logic signed [47:0] force_x,
	output logic signed [47:0] force_y,
	output logic signed [47:0] force_z,
	output logic signed [47:0] total_energy,
	output logic               last_result
);
	import lj_pkg::*;

	lj_cfg_t  cfg_q;
	lj_item_t head;
	logic     head_valid, head_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.well_depth <= 32'd16777216;
			cfg_q.sigma      <= 32'd16777216;
			cfg_q.shift      <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WELL_DEPTH: cfg_q.well_depth <= cfg_data;
				REG_SIGMA:      cfg_q.sigma      <= cfg_data;
				REG_SHIFT:      cfg_q.shift      <= cfg_data;
				default: ;
			endcase
		end
	end

	lj_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.has_pair(has_pair), .first_atom(first_atom), .second_atom(second_atom),
		.delta_x(delta_x), .delta_y(delta_y), .delta_z(delta_z),
		.separation(separation), .atom_count(atom_count), .frame_end(frame_end),
		.head(head), .head_valid(head_valid), .head_pop(head_pop)
	);

	lj_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .head(head), .head_valid(head_valid),
		.head_pop(head_pop), .out_valid(out_valid), .out_ready(out_ready),
		.atom_index(atom_index), .force_x(force_x), .force_y(force_y), .force_z(force_z),
		.total_energy(total_energy), .last_result(last_result)
	);

endmodule
